@@ hdl/text_char_converter_assert.svh @@
// Assertion macros used by the converter top level
`ifndef TEXT_CHAR_CONVERTER_ASSERT_SVH
`define TEXT_CHAR_CONVERTER_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define TCC_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define TCC_CHECK_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ hdl/tcc_pkg.sv @@
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int unsigned RunDepth = 4;

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_PASS     = 3'd0;
    localparam mode_t MODE_ROT13    = 3'd1;
    localparam mode_t MODE_UPPER    = 3'd2;
    localparam mode_t MODE_LOWER    = 3'd3;
    localparam mode_t MODE_HEX      = 3'd4;
    localparam mode_t MODE_HEX_TRIM = 3'd5;

    localparam logic [7:0] ROT_AMOUNT = 8'd13;
    localparam logic [7:0] CASE_DELTA = 8'd32;
    localparam logic [7:0] HEX_ALPHA  = 8'd10;

    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_1  = 8'h31;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UF = 8'h46;
    localparam logic [7:0] CHAR_UM = 8'h4D;
    localparam logic [7:0] CHAR_UN = 8'h4E;
    localparam logic [7:0] CHAR_UZ = 8'h5A;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LF = 8'h66;
    localparam logic [7:0] CHAR_LM = 8'h6D;
    localparam logic [7:0] CHAR_LN = 8'h6E;
    localparam logic [7:0] CHAR_LZ = 8'h7A;

    typedef logic [2:0] run_cnt_t;

    typedef struct packed {
        logic [RunDepth-1:0][7:0] chars;
        run_cnt_t                 cnt;
        logic                     set_seen;
    } conv_t;

endpackage

@@ hdl/tcc_in_if.sv @@
`timescale 1ns / 1ps

interface tcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       first_of_string;

    modport source (output valid, output in_char, output first_of_string, input ready);
    modport sink (input valid, input in_char, input first_of_string, output ready);
endinterface

@@ hdl/tcc_out_if.sv @@
`timescale 1ns / 1ps

interface tcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ hdl/tcc_convert.sv @@
`timescale 1ns / 1ps

module tcc_convert
    import tcc_pkg::*;
(
    input  logic [7:0] in_char,
    input  mode_t      mode,
    input  logic       seen,
    output conv_t      conv
);

    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] rot_char;
    run_cnt_t   lead_cnt;
    run_cnt_t   bin_cnt;
    logic [3:0] aligned;
    logic [RunDepth-1:0][7:0] bin_chars;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_char >= CHAR_0 && in_char <= CHAR_9)
        begin
            hex_val = 4'(in_char - CHAR_0);
        end
        else if (in_char >= CHAR_UA && in_char <= CHAR_UF)
        begin
            hex_val = 4'(in_char - CHAR_UA + HEX_ALPHA);
        end
        else if (in_char >= CHAR_LA && in_char <= CHAR_LF)
        begin
            hex_val = 4'(in_char - CHAR_LA + HEX_ALPHA);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        if ((in_char >= CHAR_UA && in_char <= CHAR_UM) ||
            (in_char >= CHAR_LA && in_char <= CHAR_LM))
        begin
            rot_char = in_char + ROT_AMOUNT;
        end
        else if ((in_char >= CHAR_UN && in_char <= CHAR_UZ) ||
                 (in_char >= CHAR_LN && in_char <= CHAR_LZ))
        begin
            rot_char = in_char - ROT_AMOUNT;
        end
        else
        begin
            rot_char = in_char;
        end
    end

    // count of bits from the leading one down
    always_comb
    begin
        if (hex_val[3])
        begin
            lead_cnt = 3'd4;
        end
        else if (hex_val[2])
        begin
            lead_cnt = 3'd3;
        end
        else if (hex_val[1])
        begin
            lead_cnt = 3'd2;
        end
        else if (hex_val[0])
        begin
            lead_cnt = 3'd1;
        end
        else
        begin
            lead_cnt = 3'd0;
        end
    end

    assign bin_cnt = (mode == MODE_HEX_TRIM && !seen) ? lead_cnt : 3'd4;
    assign aligned = hex_val << (3'd4 - bin_cnt);

    always_comb
    begin
        for (int k = 0; k < RunDepth; k++)
        begin
            bin_chars[k] = aligned[RunDepth-1-k] ? CHAR_1 : CHAR_0;
        end
    end

    always_comb
    begin
        conv = '0;
        case (mode)
            MODE_PASS:
            begin
                conv.chars[0] = in_char;
                conv.cnt      = 3'd1;
            end
            MODE_ROT13:
            begin
                conv.chars[0] = rot_char;
                conv.cnt      = 3'd1;
            end
            MODE_UPPER:
            begin
                conv.chars[0] = (in_char >= CHAR_LA && in_char <= CHAR_LZ) ?
                                in_char - CASE_DELTA : in_char;
                conv.cnt      = 3'd1;
            end
            MODE_LOWER:
            begin
                conv.chars[0] = (in_char >= CHAR_UA && in_char <= CHAR_UZ) ?
                                in_char + CASE_DELTA : in_char;
                conv.cnt      = 3'd1;
            end
            MODE_HEX, MODE_HEX_TRIM:
            begin
                if (hex_ok)
                begin
                    conv.chars    = bin_chars;
                    conv.cnt      = bin_cnt;
                    conv.set_seen = (mode == MODE_HEX_TRIM) && (bin_cnt != 3'd0);
                end
            end
            default:
            begin
                conv = '0;
            end
        endcase
    end

endmodule

@@ hdl/text_char_converter.sv @@
// Channel | Dir | Payload                      | Handshake
// din     | in  | in_char[7:0], first_of_string | valid/ready
// dout    | out | out_char[7:0], last_of_run    | valid/ready
// mode    | cfg | mode_wdata[2:0]              | mode_we
//
// Pass, rot13, upper and lower emit one character per request; hex modes emit
// up to four, one character per cycle while dout is ready.
// Data passes an input register, then the result run register.
// Reset clears the mode, the trim flag and both valid stages.
// A stalled output holds the run; the input register keeps taking requests
// while the last character of a run leaves.
`timescale 1ns / 1ps

`include "text_char_converter_assert.svh"

module text_char_converter
    import tcc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tcc_in_if.sink        din,
    tcc_out_if.source     dout,
    input  logic          mode_we,
    input  logic [2:0]    mode_wdata
);

    mode_t      mode_reg;
    logic       seen_reg, seen_next;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_first_reg;
    run_cnt_t   run_cnt_reg, run_cnt_next;
    logic [RunDepth-1:0][7:0] run_char_reg, run_char_next;

    logic  seen_eff;
    logic  take;
    logic  load;
    logic  accept;
    conv_t conv;

    assign seen_eff = in_first_reg ? 1'b0 : seen_reg;

    tcc_convert u_convert (
        .in_char (in_char_reg),
        .mode    (mode_reg),
        .seen    (seen_eff),
        .conv    (conv)
    );

    assign take   = dout.valid && dout.ready;
    assign load   = in_valid_reg &&
                    (run_cnt_reg == 3'd0 || (run_cnt_reg == 3'd1 && take));
    assign accept = din.valid && din.ready;

    assign din.ready        = !in_valid_reg || load;
    assign dout.valid       = run_cnt_reg != 3'd0;
    assign dout.out_char    = run_char_reg[0];
    assign dout.last_of_run = run_cnt_reg == 3'd1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        seen_next     = seen_reg;
        run_cnt_next  = run_cnt_reg;
        run_char_next = run_char_reg;
        if (load)
        begin
            seen_next     = seen_eff | conv.set_seen;
            run_cnt_next  = conv.cnt;
            run_char_next = conv.chars;
        end
        else if (take)
        begin
            // advance to the next character of the run
            run_cnt_next  = run_cnt_reg - 3'd1;
            run_char_next = {8'h00, run_char_reg[RunDepth-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_PASS;
            seen_reg     <= 1'b0;
            in_valid_reg <= 1'b0;
            run_cnt_reg  <= 3'd0;
        end
        else
        begin
            if (mode_we)
            begin
                mode_reg <= mode_wdata;
            end
            seen_reg     <= seen_next;
            in_valid_reg <= in_valid_next;
            run_cnt_reg  <= run_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg  <= din.in_char;
            in_first_reg <= din.first_of_string;
        end
        run_char_reg <= run_char_next;
    end

    `TCC_CHECK(a_run_depth, run_cnt_reg <= 3'(RunDepth), "run count beyond buffer depth")
    `TCC_CHECK_NEXT(a_run_hold, dout.valid && !dout.ready, $stable(run_cnt_reg), "stalled run moved")
    `TCC_CHECK(a_in_stall, !(in_valid_reg && !din.ready) || run_cnt_reg != 3'd0, "input stalled with empty run")

endmodule
